### rtl/gif_lzw_decoder_macros.svh
// assertion macros for the gif lzw decoder
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef GIF_LZW_DECODER_MACROS_SVH
`define GIF_LZW_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define GLZ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("gif lzw decoder assertion failed");
`define GLZ_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("gif lzw decoder reset assertion failed");
`else
`define GLZ_ASSERT(label, clk, rst_n, prop)
`define GLZ_ASSERT_RST(label, clk, prop)
`endif
`endif

### rtl/glzw_pkg.sv
// package for the gif lzw decoder: widths, codes, command and status values
// and the sequencer state type; no dependencies
`default_nettype none
package glzw_pkg;
    localparam int MaxCodeBits  = 12;
    localparam int TableSize    = 1 << MaxCodeBits;
    localparam int BitBufBits   = 32;
    localparam int AddrW        = 12;
    localparam int DepthW       = 13;
    localparam int HeldW        = 6;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_PUSH  = 2'd1,
        CMD_PULL  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_PIXEL   = 3'd0,
        ST_NEED    = 3'd1,
        ST_END     = 3'd2,
        ST_ACCEPT  = 3'd3,
        ST_FULL    = 3'd4,
        ST_CORRUPT = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        PH_RUN     = 2'd0,
        PH_FRESH   = 2'd1,
        PH_ENDED   = 2'd2,
        PH_CORRUPT = 2'd3
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP,
        S_CODE,
        S_WALK_RD,
        S_WALK,
        S_LAST,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

### rtl/gif_lzw_decoder.sv
// gif lzw decoder top level: command channel, configuration channel, result channel
// uses glzw_pkg and gif_lzw_decoder_macros.svh
//
// usage: s_axis carries one command item: cmd in tuser, data_byte in tdata and
// final_byte in tlast. every command gives exactly one result item on m_axis:
// pixel_index in tdata, status in tuser (pixel is 0 unless status is pixel).
// the cfg channel writes min_code_size, taken at the next start command.
// a start, push or unknown command goes straight to the output state on acceptance;
// a pull that pops the string stack first waits on one registered stack read.
// a pull that decodes a code walks the prefix chain one table read per symbol,
// as the prefix/suffix tables have a single read port; a clear code met sends it
// back to fetch the next code. the symbols land on the stack and later pulls pop them.
// s_axis_tready is high only in idle: one command is worked at a time.
// the result is held in an output register; while m_axis_tready is low the
// block waits with the result and takes no new command.
// reset equals a start with min_code_size 8; the tables and stack are not
// cleared (entries are always written before being read), so no clearing pass.
`default_nettype none
`include "gif_lzw_decoder_macros.svh"
module gif_lzw_decoder
    import glzw_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  wire logic [1:0]  s_axis_tuser,   // cmd[1:0]
    input  wire logic        s_axis_tlast,   // final_byte
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_data,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // pixel_index[7:0]
    output logic [2:0]       m_axis_tuser    // status[2:0]
);
    // memories
    logic [AddrW-1:0] r_prefix [TableSize];
    logic [7:0]       r_suffix [TableSize];
    logic [7:0]       r_stack  [TableSize];

    t_state r_state, n_state;
    logic [3:0]  r_mcs;
    logic [3:0]  r_lsz, n_lsz;
    logic [DepthW-1:0] r_depth, n_depth;
    logic [BitBufBits-1:0] r_buf, n_buf;
    logic [HeldW-1:0] r_held, n_held;
    logic [3:0]  r_cbits, n_cbits;
    logic [DepthW-1:0] r_nfc, n_nfc;
    logic [DepthW-1:0] r_lim, n_lim;
    logic [AddrW-1:0] r_first, n_first;
    logic [AddrW-1:0] r_prev, n_prev;
    t_phase r_ph, n_ph;
    logic   r_finseen, n_finseen;
    logic [AddrW-1:0] r_code, n_code;
    logic [AddrW-1:0] r_incode, n_incode;
    logic [DepthW-1:0] r_steps, n_steps;
    logic [7:0]  r_pix, n_pix;
    t_status r_st, n_st;
    logic        r_ovalid, n_ovalid;

    // memory ports
    logic             stk_we, tab_we;
    logic [AddrW-1:0] stk_waddr, stk_raddr, tab_waddr, tab_raddr;
    logic [7:0]       stk_wdata, suf_wdata;
    logic [AddrW-1:0] pre_wdata;
    logic [7:0]       r_stk_rd, r_suf_rd;
    logic [AddrW-1:0] r_pre_rd;

    always_ff @(posedge i_clk) begin
        if (stk_we) r_stack[stk_waddr] <= stk_wdata;
        r_stk_rd <= r_stack[stk_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_prefix[tab_waddr] <= pre_wdata;
            r_suffix[tab_waddr] <= suf_wdata;
        end
        r_pre_rd <= r_prefix[tab_raddr];
        r_suf_rd <= r_suffix[tab_raddr];
    end

    logic [AddrW:0] clr;
    logic [AddrW-1:0] clr12;
    logic [AddrW-1:0] code_now;
    logic [3:0] clamp_mcs;
    assign clr   = (AddrW+1)'(1) << r_lsz;
    assign clr12 = clr[AddrW-1:0];
    assign code_now = AddrW'(r_buf & ((BitBufBits'(1) << r_cbits) - BitBufBits'(1)));
    assign clamp_mcs = (r_mcs < 4'd2) ? 4'd2 : ((r_mcs > 4'd8) ? 4'd8 : r_mcs);

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_pix;
    assign m_axis_tuser  = r_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcs <= 4'd8;
        end else if (i_cfg_valid) begin
            r_mcs <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_lsz     <= 4'd8;
            r_depth   <= '0;
            r_buf     <= '0;
            r_held    <= '0;
            r_cbits   <= 4'd9;
            r_nfc     <= DepthW'(258);
            r_lim     <= DepthW'(512);
            r_first   <= '0;
            r_prev    <= '0;
            r_ph      <= PH_FRESH;
            r_finseen <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_lsz     <= n_lsz;
            r_depth   <= n_depth;
            r_buf     <= n_buf;
            r_held    <= n_held;
            r_cbits   <= n_cbits;
            r_nfc     <= n_nfc;
            r_lim     <= n_lim;
            r_first   <= n_first;
            r_prev    <= n_prev;
            r_ph      <= n_ph;
            r_finseen <= n_finseen;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code   <= n_code;
        r_incode <= n_incode;
        r_steps  <= n_steps;
        r_pix    <= n_pix;
        r_st     <= n_st;
    end

    always_comb begin
        logic [AddrW:0] c2;
        n_state = r_state; n_lsz = r_lsz; n_depth = r_depth; n_buf = r_buf;
        n_held = r_held; n_cbits = r_cbits; n_nfc = r_nfc; n_lim = r_lim;
        n_first = r_first; n_prev = r_prev; n_ph = r_ph; n_finseen = r_finseen;
        n_ovalid = r_ovalid;
        n_code = r_code; n_incode = r_incode; n_steps = r_steps;
        n_pix = r_pix; n_st = r_st;
        stk_we = 1'b0; stk_waddr = r_depth[AddrW-1:0]; stk_wdata = '0;
        stk_raddr = r_depth[AddrW-1:0] - AddrW'(1);
        tab_we = 1'b0; tab_waddr = r_nfc[AddrW-1:0]; pre_wdata = r_prev;
        suf_wdata = r_first[7:0]; tab_raddr = r_code;
        c2 = '0;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_pix  = '0;
                    n_st   = ST_ACCEPT;
                    n_state = S_OUT;
                    unique case (t_cmd'(s_axis_tuser))
                        CMD_START: begin
                            n_lsz = clamp_mcs;
                            c2 = (AddrW+1)'(1) << clamp_mcs;
                            n_cbits = clamp_mcs + 4'd1;
                            n_nfc = DepthW'(c2) + DepthW'(2);
                            n_lim = DepthW'(c2) << 1;
                            n_depth = '0; n_buf = '0; n_held = '0;
                            n_first = '0; n_prev = '0;
                            n_ph = PH_FRESH; n_finseen = 1'b0;
                        end
                        CMD_PUSH: begin
                            if (32'(r_held) + 32'd8 > 32'(BitBufBits)) begin
                                n_st = ST_FULL;
                            end else begin
                                n_buf = r_buf | (BitBufBits'(s_axis_tdata) << r_held);
                                n_held = r_held + HeldW'(8);
                                if (s_axis_tlast) n_finseen = 1'b1;
                            end
                        end
                        CMD_PULL: n_state = S_CODE;
                        CMD_NONE: ;
                        default: ;
                    endcase
                end
            end
            S_CODE: begin
                n_state = S_OUT;
                if (r_ph == PH_CORRUPT) begin
                    n_st = ST_CORRUPT;
                end else if (r_ph == PH_ENDED) begin
                    n_st = ST_END;
                end else if (r_depth != '0) begin
                    n_depth = r_depth - DepthW'(1);
                    n_state = S_POP;
                end else if (r_held < HeldW'(r_cbits)) begin
                    if (r_finseen) begin n_ph = PH_ENDED; n_st = ST_END; end
                    else n_st = ST_NEED;
                end else begin
                    n_buf  = r_buf >> r_cbits;
                    n_held = r_held - HeldW'(r_cbits);
                    if ({1'b0, code_now} == clr) begin
                        n_cbits = r_lsz + 4'd1;
                        n_nfc = DepthW'(clr) + DepthW'(2);
                        n_lim = DepthW'(clr) << 1;
                        n_depth = '0;
                        n_ph = PH_FRESH;
                        n_state = S_CODE;
                    end else if ({1'b0, code_now} == clr + (AddrW+1)'(1)) begin
                        n_ph = PH_ENDED; n_st = ST_END;
                    end else if (r_ph == PH_FRESH) begin
                        if ({1'b0, code_now} > clr) begin
                            n_ph = PH_CORRUPT; n_st = ST_CORRUPT;
                        end else begin
                            n_first = code_now; n_prev = code_now;
                            n_ph = PH_RUN; n_st = ST_PIXEL;
                            n_pix = code_now[7:0];
                        end
                    end else if ({1'b0, code_now} > r_nfc) begin
                        n_depth = '0; n_ph = PH_CORRUPT; n_st = ST_CORRUPT;
                    end else begin
                        n_incode = code_now;
                        n_steps = '0;
                        n_code = code_now;
                        if ({1'b0, code_now} == r_nfc) begin
                            // kwkwk: the first symbol of the previous string closes it
                            stk_we = 1'b1; stk_wdata = r_first[7:0];
                            n_depth = r_depth + DepthW'(1);
                            n_code = r_prev;
                        end
                        n_state = S_WALK_RD;
                    end
                end
            end
            S_WALK_RD: begin
                if ({1'b0, r_code} >= clr) begin
                    if (r_steps >= DepthW'(TableSize) || r_depth >= DepthW'(TableSize)) begin
                        n_depth = '0; n_ph = PH_CORRUPT; n_st = ST_CORRUPT;
                        n_state = S_OUT;
                    end else begin
                        tab_raddr = r_code;
                        n_steps = r_steps + DepthW'(1);
                        n_state = S_WALK;
                    end
                end else begin
                    n_state = S_LAST;
                end
            end
            S_WALK: begin
                stk_we = 1'b1; stk_wdata = r_suf_rd;
                n_depth = r_depth + DepthW'(1);
                n_code = r_pre_rd;
                n_state = S_WALK_RD;
            end
            S_LAST: begin
                n_first = r_code;
                if (r_depth >= DepthW'(TableSize)) begin
                    n_depth = '0; n_ph = PH_CORRUPT; n_st = ST_CORRUPT;
                    n_state = S_OUT;
                end else begin
                    stk_we = 1'b1; stk_wdata = r_code[7:0];
                    n_depth = r_depth + DepthW'(1);
                    if (r_nfc < DepthW'(TableSize)) begin
                        tab_we = 1'b1; pre_wdata = r_prev; suf_wdata = r_code[7:0];
                        n_nfc = r_nfc + DepthW'(1);
                        if (r_nfc + DepthW'(1) >= r_lim && r_lim < DepthW'(TableSize)) begin
                            n_lim = r_lim << 1;
                            n_cbits = r_cbits + 4'd1;
                        end
                    end
                    n_prev = r_incode;
                    n_state = S_CODE;
                end
            end
            S_POP: begin
                n_pix = r_stk_rd; n_st = ST_PIXEL;
                n_state = S_OUT;
            end
            S_OUT: begin
                n_ovalid = 1'b1;
                if (r_ovalid && m_axis_tready) begin
                    n_ovalid = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `GLZ_ASSERT(a_busy_no_ready, i_clk, i_rst_n, (r_state != S_IDLE) |-> !s_axis_tready)
    `GLZ_ASSERT(a_out_only_in_out, i_clk, i_rst_n, m_axis_tvalid |-> (r_state == S_OUT))
    `GLZ_ASSERT(a_depth_range, i_clk, i_rst_n, r_depth <= DepthW'(TableSize))
    `GLZ_ASSERT(a_cbits_range, i_clk, i_rst_n, (r_cbits >= 4'd3) && (r_cbits <= 4'd12))
    `GLZ_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> (r_state == S_IDLE) && !m_axis_tvalid)
endmodule
`default_nettype wire

### tb/testbench.sv
// self-checking testbench for gif_lzw_decoder: random lzw code streams, noise and stalls
// depends on glzw_pkg and the decoder rtl; the scoreboard class predicts every result item
`default_nettype none
module testbench;
    import glzw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] pixel;
    } t_result;

    class lzw_scoreboard;
        bit [3:0]    size_reg;
        int unsigned root_bits;
        logic [11:0] prefix_mem [TableSize];
        logic [7:0]  suffix_mem [TableSize];
        logic [7:0]  stack_mem  [TableSize];
        int unsigned depth, held, width, free_code, grow_at, first_sym, prev_code;
        bit [63:0]   bit_buf;
        t_phase      phase;
        bit          final_seen;
        t_result     pending[$];
        int          mismatches;

        function new();
            size_reg = 4'd8;
            mismatches = 0;
            begin_image();
        endfunction

        function void restart_table();
            width = root_bits + 1;
            free_code = (1 << root_bits) + 2;
            grow_at = 2 << root_bits;
            depth = 0;
        endfunction

        function void begin_image();
            root_bits = (size_reg < 2) ? 2 : (size_reg > 8) ? 8 : size_reg;
            bit_buf = '0;
            held = 0;
            first_sym = 0;
            prev_code = 0;
            phase = PH_FRESH;
            final_seen = 0;
            restart_table();
        endfunction

        function bit stack_sym(int unsigned s);
            if (depth >= TableSize) return 0;
            stack_mem[depth % TableSize] = s[7:0];
            depth++;
            return 1;
        endfunction

        // pushes the string of one code onto the stack and grows the table
        function bit decode_code(int unsigned code);
            int unsigned clr, in_code, steps;
            clr = 1 << root_bits;
            in_code = code;
            steps = 0;
            if (code > free_code) return 0;
            if (code == free_code) begin
                if (!stack_sym(first_sym)) return 0;
                code = prev_code;
            end
            while (code >= clr) begin
                steps++;
                if (steps > TableSize) return 0;
                code = code % TableSize;
                if (!stack_sym(suffix_mem[code])) return 0;
                code = prefix_mem[code];
            end
            first_sym = code;
            if (!stack_sym(code)) return 0;
            if (free_code < TableSize) begin
                prefix_mem[free_code] = prev_code[11:0];
                suffix_mem[free_code] = first_sym[7:0];
                free_code++;
                if (free_code >= grow_at && grow_at < TableSize) begin
                    grow_at *= 2;
                    width++;
                end
            end
            prev_code = in_code;
            return 1;
        endfunction

        function t_status next_pixel(output logic [7:0] pix);
            int unsigned clr, code;
            clr = 1 << root_bits;
            forever begin
                if (phase == PH_CORRUPT) return ST_CORRUPT;
                if (phase == PH_ENDED) return ST_END;
                if (depth > 0) begin
                    depth--;
                    pix = stack_mem[depth % TableSize];
                    return ST_PIXEL;
                end
                if (held < width) begin
                    if (final_seen) begin
                        phase = PH_ENDED;
                        return ST_END;
                    end
                    return ST_NEED;
                end
                code = 32'(bit_buf & ((64'd1 << width) - 64'd1));
                bit_buf >>= width;
                held -= width;
                if (code == clr) begin
                    restart_table();
                    phase = PH_FRESH;
                    continue;
                end
                if (code == clr + 1) begin
                    phase = PH_ENDED;
                    return ST_END;
                end
                if (phase == PH_FRESH) begin
                    if (code > clr) begin
                        phase = PH_CORRUPT;
                        return ST_CORRUPT;
                    end
                    first_sym = code;
                    prev_code = code;
                    phase = PH_RUN;
                    pix = code[7:0];
                    return ST_PIXEL;
                end
                if (!decode_code(code)) begin
                    depth = 0;
                    phase = PH_CORRUPT;
                    return ST_CORRUPT;
                end
            end
        endfunction

        function void note_item(t_cmd cmd, logic [7:0] data, logic fin);
            t_result r;
            logic [7:0] pix;
            pix = '0;
            r.status = ST_ACCEPT;
            case (cmd)
                CMD_START: begin
                    begin_image();
                end
                CMD_PUSH: begin
                    if (held + 8 > BitBufBits) begin
                        r.status = ST_FULL;
                    end else begin
                        bit_buf |= 64'(data) << held;
                        held += 8;
                        if (fin) final_seen = 1;
                    end
                end
                CMD_PULL: begin
                    r.status = next_pixel(pix);
                end
                default: ;
            endcase
            r.pixel = (r.status == ST_PIXEL) ? pix : 8'd0;
            pending.push_back(r);
        endfunction

        function void check_result(logic [7:0] pix, logic [2:0] st);
            t_result exp_r;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item status %0d pixel %0d", st, pix);
                return;
            end
            exp_r = pending.pop_front();
            if (st !== exp_r.status || pix !== exp_r.pixel) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected status %0d pixel %0d, got status %0d pixel %0d",
                             exp_r.status, exp_r.pixel, st, pix);
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n;
    logic        s_axis_tvalid, s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        s_axis_tlast;
    logic        i_cfg_valid, o_cfg_ready;
    logic [3:0]  i_cfg_data;
    logic        m_axis_tvalid, m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    lzw_scoreboard sb;
    int          send_idle, recv_idle, n_items;
    longint      cycles;
    // code stream builder
    logic [7:0]  stream_bytes[$];
    bit [63:0]   pack_acc;
    int          pack_bits, pack_width;

    gif_lzw_decoder u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),   // data_byte[7:0]
        .s_axis_tuser (s_axis_tuser),   // cmd[1:0]
        .s_axis_tlast (s_axis_tlast),   // final_byte
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),   // pixel_index[7:0]
        .m_axis_tuser (m_axis_tuser)    // status[2:0]
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        m_axis_tready = 0;
        forever begin
            @(negedge i_clk);
            m_axis_tready = ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_item(t_cmd cmd, logic [7:0] data, logic fin);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid = 0;
            @(negedge i_clk);
        end
        s_axis_tuser = cmd;
        s_axis_tdata = data;
        s_axis_tlast = fin;
        s_axis_tvalid = 1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_item(cmd, data, fin);
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic write_size(logic [3:0] value);
        @(negedge i_clk);
        s_axis_tvalid = 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_data = value;
        i_cfg_valid = 1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.size_reg = value;
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    task automatic pack_code(int code);
        pack_acc |= 64'(code) << pack_bits;
        pack_bits += pack_width;
        while (pack_bits >= 8) begin
            stream_bytes.push_back(pack_acc[7:0]);
            pack_acc >>= 8;
            pack_bits -= 8;
        end
    endtask

    // kind: 0 normal, 1 leading clears, 2 first code not literal,
    // 3 code beyond the free code, 4 end code first
    task automatic run_image(int kind);
        int clr, free_code, grow_at, n_codes, c, bad_at, idx;
        bit fresh, mark_final, fits;
        send_item(CMD_START, 8'($urandom), 1'($urandom));
        clr = 1 << sb.root_bits;
        stream_bytes.delete();
        pack_acc = '0;
        pack_bits = 0;
        pack_width = sb.root_bits + 1;
        free_code = clr + 2;
        grow_at = 2 * clr;
        fresh = 1;
        n_codes = $urandom_range(3, 60);
        bad_at = $urandom_range(1, n_codes);
        if (kind == 1) begin
            pack_code(clr);
            pack_code(clr);
        end
        if (kind == 4) begin
            pack_code(clr + 1);
            n_codes = 0;
        end else if (kind == 2) begin
            pack_code($urandom_range(clr + 2, (1 << pack_width) - 1));
            n_codes = 0;
        end
        for (int i = 0; i < n_codes; i++) begin
            if (!fresh && $urandom_range(99) < 3) begin
                pack_code(clr);
                pack_width = sb.root_bits + 1;
                free_code = clr + 2;
                grow_at = 2 * clr;
                fresh = 1;
                continue;
            end
            if (fresh) begin
                pack_code($urandom_range(clr - 1));
                fresh = 0;
                continue;
            end
            if (kind == 3 && i >= bad_at && free_code + 1 < (1 << pack_width)) begin
                pack_code($urandom_range(free_code + 1, (1 << pack_width) - 1));
                break;
            end
            if ($urandom_range(1)) c = $urandom_range(clr - 1);
            else c = $urandom_range(clr + 2, (free_code > 4095) ? 4095 : free_code);
            pack_code(c);
            if (free_code < TableSize) begin
                free_code++;
                if (free_code >= grow_at && grow_at < TableSize) begin
                    grow_at *= 2;
                    pack_width++;
                end
            end
        end
        if ($urandom_range(1)) pack_code(clr + 1);
        if (pack_bits > 0) stream_bytes.push_back(pack_acc[7:0]);
        mark_final = ($urandom_range(9) < 7);

        idx = 0;
        while (sb.phase != PH_ENDED && sb.phase != PH_CORRUPT
               && !(idx == stream_bytes.size() && sb.depth == 0 && sb.held < sb.width)) begin
            fits = (sb.held + 8 <= BitBufBits);
            if (idx < stream_bytes.size() && $urandom_range(1)
                && (fits || $urandom_range(19) == 0)) begin
                send_item(CMD_PUSH, stream_bytes[idx],
                          mark_final && idx == stream_bytes.size() - 1);
                if (fits) idx++;
            end else begin
                send_item(CMD_PULL, 8'($urandom), 1'($urandom));
            end
        end
        // trailing pulls, at times a push or an unknown command, after the end, corruption or exhaustion of the stream
        repeat ($urandom_range(1, 3)) send_item(CMD_PULL, 8'($urandom), 1'($urandom));
        if ($urandom_range(3) == 0) send_item(CMD_PUSH, 8'($urandom), 1'($urandom));
        if ($urandom_range(9) == 0) send_item(CMD_NONE, 8'($urandom), 1'($urandom));
    endtask

    initial begin
        int kind;
        sb = new();
        n_items = 0;
        send_idle = 23;
        recv_idle = 72;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        s_axis_tlast = 0;
        i_cfg_valid = 0;
        i_cfg_data = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: unknown command, short of bits, buffer full, size extremes
        send_item(CMD_NONE, 8'hff, 1'b1);
        send_item(CMD_PULL, 8'h00, 1'b0);
        repeat (5) send_item(CMD_PUSH, 8'hff, 1'b1);
        send_item(CMD_PULL, 8'h00, 1'b0);
        send_item(CMD_PULL, 8'h00, 1'b0);
        write_size(4'd0);
        for (int k = 0; k <= 4; k++) run_image(k);
        write_size(4'd15);
        run_image(0);
        run_image(3);
        write_size(4'd2);
        run_image(0);
        write_size(4'd8);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 23 : (ph == 1) ? 72 : 0;
            recv_idle = (ph == 0) ? 72 : (ph == 1) ? 23 : 0;
            while (n_items < 650 * (ph + 1)) begin
                if ($urandom_range(3) == 0) write_size(4'($urandom_range(15)));
                kind = $urandom_range(99);
                kind = (kind < 80) ? 0 : (kind - 80) / 5 + 1;
                run_image(kind);
            end
        end

        @(negedge i_clk);
        s_axis_tvalid = 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire
